// File: sv/apg_pkg.sv
// Shared constants, types and angle table for the arc polyline point generator.
package apg_pkg;

	localparam int MAX_SEGMENTS   = 4096;
	localparam int CORDIC_STAGES  = 24;
	localparam int SQRT_STAGES    = 31;
	localparam int FIXED_SEGMENTS = 8;
	localparam int MIN_SEGMENTS   = 2;
	localparam int QBITS          = $clog2(MAX_SEGMENTS);
	localparam int NW             = $clog2(MAX_SEGMENTS + 1);
	localparam int OFS_BITS       = 32;
	localparam int SHW            = 5;
	localparam int REM_W          = (NW + OFS_BITS > 45) ? NW + OFS_BITS : 45;

	localparam logic signed [33:0] Q28_PI      = 34'sh03243F6A9;
	localparam logic signed [33:0] Q28_HALF_PI = 34'sh01921FB54;
	localparam logic signed [33:0] Q28_TWO_PI  = 34'sh06487ED52;
	localparam logic [29:0]        GAIN_Q30    = 30'h26DD3B6A;

	typedef logic [SHW-1:0] sh_t;
	typedef logic [NW-1:0]  cnt_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        r;
		logic signed [31:0] start;
		logic [31:0]        mag;
		logic               sneg;
		logic [12:0]        idx;
		logic               tol_ok;
		logic [31:0]        rmt;
		logic [31:0]        step;
		logic               cap;
		cnt_t               n;
		logic [REM_W-1:0]   prodm;
		logic               fneg;
	} carry_t;

	function automatic logic signed [31:0] atan_q28(input sh_t i);
		logic signed [31:0] v;
		case (int'(i))
			0: v = 32'sh0C90FDAA;
			1: v = 32'sd124459457;
			2: v = 32'sd65760959;
			3: v = 32'sd33381290;
			4: v = 32'sd16755422;
			5: v = 32'sd8385879;
			6: v = 32'sd4193963;
			7: v = 32'sd2097109;
			8: v = 32'sd1048571;
			9: v = 32'sd524287;
			default: begin
				if (int'(i) inside {[10:28]}) begin
					v = 32'(64'd1 << (28 - int'(i)));
				end else if (int'(i) == 29) begin
					v = 32'sd1;
				end else begin
					v = 32'sd0;
				end
			end
		endcase
		return v;
	endfunction

endpackage

// File: sv/arc_polyline_point_generator.sv
// Top level of the arc polyline point generator: chord-tolerance arc tessellation pipeline.
//
// Input channel in_valid/in_stall carries one arc (center, radius, start, sweep) and a
// vertex index per transaction; output channel out_valid/out_stall returns the vertex,
// the segment count and the last/beyond flags, one result per input transaction.
// Write chord_tolerance via chord_tolerance_we only while the pipeline is empty (unenforced).
// The datapath is a row of cells that all advance together: input register, 31 square
// root cells, CORDIC_STAGES vectoring cells, two count setup stages, QBITS count divider
// cells, one count select stage, 32 offset divider cells, five angle reduction stages,
// CORDIC_STAGES rotation cells, one rounding stage and the output register.
// Throughput is one transaction per cycle while the receiver does not stall a valid result.
// Reset clears all valid bits and the tolerance register (fixed eight segments).
// When the receiver stalls a valid result, the whole row holds and in_stall rises in
// the same cycle; the result and every item in flight are kept.
module arc_polyline_point_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               chord_tolerance_we,
	input  logic [30:0]        chord_tolerance,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic [30:0]        arc_radius,
	input  logic signed [31:0] arc_start,
	input  logic signed [31:0] sweep_angle,
	input  logic [12:0]        point_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic [12:0]        segment_count,
	output logic               last_point,
	output logic               index_beyond
);

	localparam int SQN = apg_pkg::SQRT_STAGES;
	localparam int CSN = apg_pkg::CORDIC_STAGES;
	localparam int QBN = apg_pkg::QBITS;
	localparam int OFN = apg_pkg::OFS_BITS;
	localparam int RW  = apg_pkg::REM_W;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] res;
		if (v > 35'sd2147483647) begin
			res = 32'sh7FFFFFFF;
		end else if (v < -35'sd2147483648) begin
			res = 32'sh80000000;
		end else begin
			res = v[31:0];
		end
		return res;
	endfunction

	function automatic logic signed [33:0] mod_step(input logic signed [33:0] a);
		logic signed [33:0] res;
		if (a >= apg_pkg::Q28_TWO_PI) begin
			res = a - apg_pkg::Q28_TWO_PI;
		end else if (a <= -apg_pkg::Q28_TWO_PI) begin
			res = a + apg_pkg::Q28_TWO_PI;
		end else begin
			res = a;
		end
		return res;
	endfunction

	logic        adv;
	logic [30:0] chord_tolerance_q;

	assign in_stall = out_valid & out_stall;
	assign adv      = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chord_tolerance_q <= '0;
		end else if (chord_tolerance_we) begin
			chord_tolerance_q <= chord_tolerance;
		end
	end

	// input stage
	logic [31:0]     twor_t;
	logic [62:0]     sq_prod;
	logic [31:0]     mag_w;
	logic [RW-1:0]   prodm_w;
	apg_pkg::carry_t cry_in;
	logic            vld_s1;
	apg_pkg::carry_t cry_s1;
	logic [63:0]     sqv_s1;

	always_comb begin
		twor_t  = {arc_radius, 1'b0} - {1'b0, chord_tolerance_q};
		sq_prod = 63'(chord_tolerance_q) * 63'(twor_t);
		mag_w   = sweep_angle[31] ? 32'(-sweep_angle) : sweep_angle;
		prodm_w = RW'(mag_w) * RW'(point_index);
		cry_in.cx     = center_x;
		cry_in.cy     = center_y;
		cry_in.r      = arc_radius;
		cry_in.start  = arc_start;
		cry_in.mag    = mag_w;
		cry_in.sneg   = sweep_angle[31];
		cry_in.idx    = point_index;
		cry_in.tol_ok = (chord_tolerance_q != '0) && (chord_tolerance_q < arc_radius);
		cry_in.rmt    = {1'b0, arc_radius} - {1'b0, chord_tolerance_q};
		cry_in.step   = '0;
		cry_in.cap    = 1'b0;
		cry_in.n      = '0;
		cry_in.prodm  = prodm_w;
		cry_in.fneg   = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cry_s1 <= cry_in;
			sqv_s1 <= 64'(sq_prod);
		end
	end

	// square root row
	logic            sq_vld [0:SQN];
	apg_pkg::carry_t sq_cry [0:SQN];
	logic [63:0]     sq_v   [0:SQN];
	logic [63:0]     sq_res [0:SQN];

	assign sq_vld[0] = vld_s1;
	assign sq_cry[0] = cry_s1;
	assign sq_v[0]   = sqv_s1;
	assign sq_res[0] = '0;

	for (genvar k = 0; k < SQN; k++) begin : g_sqrt
		apg_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.stage   (apg_pkg::sh_t'(k)),
			.in_vld  (sq_vld[k]),
			.in_cry  (sq_cry[k]),
			.in_v    (sq_v[k]),
			.in_res  (sq_res[k]),
			.out_vld (sq_vld[k+1]),
			.out_cry (sq_cry[k+1]),
			.out_v   (sq_v[k+1]),
			.out_res (sq_res[k+1])
		);
	end

	// vectoring row: half step angle
	logic               vc_vld [0:CSN];
	apg_pkg::carry_t    vc_cry [0:CSN];
	logic signed [63:0] vc_x   [0:CSN];
	logic signed [63:0] vc_y   [0:CSN];
	logic signed [31:0] vc_z   [0:CSN];

	assign vc_vld[0] = sq_vld[SQN];
	assign vc_cry[0] = sq_cry[SQN];
	assign vc_x[0]   = {16'd0, sq_cry[SQN].rmt, 16'd0};
	assign vc_y[0]   = {sq_res[SQN][47:0], 16'd0};
	assign vc_z[0]   = '0;

	for (genvar k = 0; k < CSN; k++) begin : g_vect
		apg_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vect    (1'b1),
			.stage   (apg_pkg::sh_t'(k)),
			.in_vld  (vc_vld[k]),
			.in_cry  (vc_cry[k]),
			.in_x    (vc_x[k]),
			.in_y    (vc_y[k]),
			.in_z    (vc_z[k]),
			.out_vld (vc_vld[k+1]),
			.out_cry (vc_cry[k+1]),
			.out_x   (vc_x[k+1]),
			.out_y   (vc_y[k+1]),
			.out_z   (vc_z[k+1])
		);
	end

	// count setup
	logic            vld_c1;
	apg_pkg::carry_t cry_c1;
	logic [RW-1:0]   num_c1;
	logic            vld_c2;
	apg_pkg::carry_t cry_c2;
	logic [RW-1:0]   num_c2;
	logic [RW-1:0]   cap_lim;
	apg_pkg::carry_t cry_set_w;
	apg_pkg::carry_t cry_cap_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
			vld_c2 <= 1'b0;
		end else if (adv) begin
			vld_c1 <= vc_vld[CSN];
			vld_c2 <= vld_c1;
		end
	end

	assign cap_lim = RW'(cry_c1.step) * RW'(apg_pkg::MAX_SEGMENTS);

	always_comb begin
		cry_set_w      = vc_cry[CSN];
		cry_set_w.step = {vc_z[CSN][30:0], 1'b0};
		cry_set_w.cap  = vc_z[CSN][31] || (vc_z[CSN] == '0);
		cry_cap_w      = cry_c1;
		cry_cap_w.cap  = cry_c1.cap || (num_c1 >= cap_lim);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cry_c1 <= cry_set_w;
			num_c1 <= RW'(vc_cry[CSN].mag) + RW'({vc_z[CSN][30:0], 1'b0}) - RW'(1);
			cry_c2 <= cry_cap_w;
			num_c2 <= num_c1;
		end
	end

	// count divider row
	logic            cd_vld [0:QBN];
	apg_pkg::carry_t cd_cry [0:QBN];
	logic [RW-1:0]   cd_rem [0:QBN];
	logic [31:0]     cd_q   [0:QBN];

	assign cd_vld[0] = vld_c2;
	assign cd_cry[0] = cry_c2;
	assign cd_rem[0] = num_c2;
	assign cd_q[0]   = '0;

	for (genvar k = 0; k < QBN; k++) begin : g_cdiv
		apg_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.shift   (apg_pkg::sh_t'(QBN - 1 - k)),
			.divisor (cd_cry[k].step),
			.in_vld  (cd_vld[k]),
			.in_cry  (cd_cry[k]),
			.in_rem  (cd_rem[k]),
			.in_q    (cd_q[k]),
			.out_vld (cd_vld[k+1]),
			.out_cry (cd_cry[k+1]),
			.out_rem (cd_rem[k+1]),
			.out_q   (cd_q[k+1])
		);
	end

	// count select
	apg_pkg::cnt_t   n_w;
	apg_pkg::carry_t cry_sel_w;
	logic            vld_c3;
	apg_pkg::carry_t cry_c3;

	always_comb begin
		if (!cd_cry[QBN].tol_ok) begin
			n_w = apg_pkg::cnt_t'(apg_pkg::FIXED_SEGMENTS);
		end else if (cd_cry[QBN].cap) begin
			n_w = apg_pkg::cnt_t'(apg_pkg::MAX_SEGMENTS);
		end else if (cd_q[QBN] < 32'(apg_pkg::MIN_SEGMENTS)) begin
			n_w = apg_pkg::cnt_t'(apg_pkg::MIN_SEGMENTS);
		end else begin
			n_w = apg_pkg::cnt_t'(cd_q[QBN]);
		end
		cry_sel_w   = cd_cry[QBN];
		cry_sel_w.n = n_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c3 <= 1'b0;
		end else if (adv) begin
			vld_c3 <= cd_vld[QBN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cry_c3 <= cry_sel_w;
		end
	end

	// offset divider row
	logic            od_vld [0:OFN];
	apg_pkg::carry_t od_cry [0:OFN];
	logic [RW-1:0]   od_rem [0:OFN];
	logic [31:0]     od_q   [0:OFN];

	assign od_vld[0] = vld_c3;
	assign od_cry[0] = cry_c3;
	assign od_rem[0] = cry_c3.prodm;
	assign od_q[0]   = '0;

	for (genvar k = 0; k < OFN; k++) begin : g_odiv
		apg_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.shift   (apg_pkg::sh_t'(OFN - 1 - k)),
			.divisor (32'(od_cry[k].n)),
			.in_vld  (od_vld[k]),
			.in_cry  (od_cry[k]),
			.in_rem  (od_rem[k]),
			.in_q    (od_q[k]),
			.out_vld (od_vld[k+1]),
			.out_cry (od_cry[k+1]),
			.out_rem (od_rem[k+1]),
			.out_q   (od_q[k+1])
		);
	end

	// angle reduction
	logic signed [33:0] qmag;
	logic signed [33:0] ang_a1;
	logic signed [33:0] ang_r1;
	logic signed [33:0] ang_r2;
	logic signed [33:0] ang_r3;
	logic signed [33:0] ang_r4;
	logic               vld_a1;
	logic               vld_r1;
	logic               vld_r2;
	logic               vld_r3;
	logic               vld_r4;
	apg_pkg::carry_t    cry_a1;
	apg_pkg::carry_t    cry_r1;
	apg_pkg::carry_t    cry_r2;
	apg_pkg::carry_t    cry_r3;
	apg_pkg::carry_t    cry_r4;
	logic [60:0]        rot_x0;
	logic signed [63:0] x0_r4;
	apg_pkg::carry_t    cry_fold_w;
	logic signed [33:0] ang_fold_w;

	assign qmag   = signed'({2'b00, od_q[OFN]});
	assign rot_x0 = 61'(cry_r3.r) * 61'(apg_pkg::GAIN_Q30);

	always_comb begin
		cry_fold_w = cry_r3;
		if (ang_r3 > apg_pkg::Q28_HALF_PI) begin
			ang_fold_w      = ang_r3 - apg_pkg::Q28_PI;
			cry_fold_w.fneg = 1'b1;
		end else if (ang_r3 < -apg_pkg::Q28_HALF_PI) begin
			ang_fold_w      = ang_r3 + apg_pkg::Q28_PI;
			cry_fold_w.fneg = 1'b1;
		end else begin
			ang_fold_w      = ang_r3;
			cry_fold_w.fneg = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a1 <= 1'b0;
			vld_r1 <= 1'b0;
			vld_r2 <= 1'b0;
			vld_r3 <= 1'b0;
			vld_r4 <= 1'b0;
		end else if (adv) begin
			vld_a1 <= od_vld[OFN];
			vld_r1 <= vld_a1;
			vld_r2 <= vld_r1;
			vld_r3 <= vld_r2;
			vld_r4 <= vld_r3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cry_a1 <= od_cry[OFN];
			ang_a1 <= 34'(od_cry[OFN].start) + (od_cry[OFN].sneg ? -qmag : qmag);
			cry_r1 <= cry_a1;
			ang_r1 <= mod_step(ang_a1);
			cry_r2 <= cry_r1;
			ang_r2 <= mod_step(ang_r1);
			cry_r3 <= cry_r2;
			if (ang_r2 > apg_pkg::Q28_PI) begin
				ang_r3 <= ang_r2 - apg_pkg::Q28_TWO_PI;
			end else if (ang_r2 < -apg_pkg::Q28_PI) begin
				ang_r3 <= ang_r2 + apg_pkg::Q28_TWO_PI;
			end else begin
				ang_r3 <= ang_r2;
			end
			cry_r4 <= cry_fold_w;
			x0_r4  <= signed'(64'(rot_x0));
			ang_r4 <= ang_fold_w;
		end
	end

	// rotation row
	logic               rc_vld [0:CSN];
	apg_pkg::carry_t    rc_cry [0:CSN];
	logic signed [63:0] rc_x   [0:CSN];
	logic signed [63:0] rc_y   [0:CSN];
	logic signed [31:0] rc_z   [0:CSN];

	assign rc_vld[0] = vld_r4;
	assign rc_cry[0] = cry_r4;
	assign rc_x[0]   = x0_r4;
	assign rc_y[0]   = '0;
	assign rc_z[0]   = 32'(ang_r4);

	for (genvar k = 0; k < CSN; k++) begin : g_rot
		apg_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vect    (1'b0),
			.stage   (apg_pkg::sh_t'(k)),
			.in_vld  (rc_vld[k]),
			.in_cry  (rc_cry[k]),
			.in_x    (rc_x[k]),
			.in_y    (rc_y[k]),
			.in_z    (rc_z[k]),
			.out_vld (rc_vld[k+1]),
			.out_cry (rc_cry[k+1]),
			.out_x   (rc_x[k+1]),
			.out_y   (rc_y[k+1]),
			.out_z   (rc_z[k+1])
		);
	end

	// rounding and output
	logic signed [63:0] rx_sum;
	logic signed [63:0] ry_sum;
	logic               vld_f1;
	apg_pkg::carry_t    cry_f1;
	logic signed [33:0] xr_f1;
	logic signed [33:0] yr_f1;
	logic signed [34:0] px_sum;
	logic signed [34:0] py_sum;
	logic               beyond_w;

	assign rx_sum = rc_x[CSN] + 64'sd536870912;
	assign ry_sum = rc_y[CSN] + 64'sd536870912;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_f1    <= rc_vld[CSN];
			out_valid <= vld_f1;
		end
	end

	always_comb begin
		if (cry_f1.fneg) begin
			px_sum = 35'(cry_f1.cx) - 35'(xr_f1);
			py_sum = 35'(cry_f1.cy) - 35'(yr_f1);
		end else begin
			px_sum = 35'(cry_f1.cx) + 35'(xr_f1);
			py_sum = 35'(cry_f1.cy) + 35'(yr_f1);
		end
		beyond_w = int'(cry_f1.idx) > int'(cry_f1.n);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cry_f1        <= rc_cry[CSN];
			xr_f1         <= 34'(rx_sum >>> 30);
			yr_f1         <= 34'(ry_sum >>> 30);
			point_x       <= beyond_w ? 32'sd0 : sat32(px_sum);
			point_y       <= beyond_w ? 32'sd0 : sat32(py_sum);
			segment_count <= 13'(cry_f1.n);
			last_point    <= int'(cry_f1.idx) == int'(cry_f1.n);
			index_beyond  <= beyond_w;
		end
	end

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(last_point && index_beyond))
		else $error("last_point and index_beyond both set");

	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_beyond |-> point_x == 32'sd0 && point_y == 32'sd0)
		else $error("point not cleared beyond count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_c3 |-> int'(cry_c3.n) >= apg_pkg::MIN_SEGMENTS
			&& int'(cry_c3.n) <= apg_pkg::MAX_SEGMENTS)
		else $error("segment count out of range");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_f1) && $stable(vld_c3))
		else $error("pipeline moved while stalled");

endmodule

// File: sv/apg_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module apg_sqrt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  apg_pkg::sh_t     stage,
	input  logic             in_vld,
	input  apg_pkg::carry_t  in_cry,
	input  logic [63:0]      in_v,
	input  logic [63:0]      in_res,
	output logic             out_vld,
	output apg_pkg::carry_t  out_cry,
	output logic [63:0]      out_v,
	output logic [63:0]      out_res
);

	logic [6:0]  shamt;
	logic [63:0] bitv;
	logic [63:0] trial;
	logic [63:0] nv;
	logic [63:0] nres;

	always_comb begin
		shamt = 7'(2 * (apg_pkg::SQRT_STAGES - 1 - int'(stage)));
		bitv  = 64'd1 << shamt;
		trial = in_res + bitv;
		if (in_v >= trial) begin
			nv   = in_v - trial;
			nres = (in_res >> 1) + bitv;
		end else begin
			nv   = in_v;
			nres = in_res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_cry <= in_cry;
			out_v   <= nv;
			out_res <= nres;
		end
	end

endmodule

// File: sv/apg_cordic_cell.sv
// One CORDIC micro-rotation, vectoring or rotation mode.
module apg_cordic_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vect,
	input  apg_pkg::sh_t       stage,
	input  logic               in_vld,
	input  apg_pkg::carry_t    in_cry,
	input  logic signed [63:0] in_x,
	input  logic signed [63:0] in_y,
	input  logic signed [31:0] in_z,
	output logic               out_vld,
	output apg_pkg::carry_t    out_cry,
	output logic signed [63:0] out_x,
	output logic signed [63:0] out_y,
	output logic signed [31:0] out_z
);

	logic               pos;
	logic signed [63:0] xs;
	logic signed [63:0] ys;
	logic signed [31:0] at;
	logic signed [63:0] nx;
	logic signed [63:0] ny;
	logic signed [31:0] nz;

	always_comb begin
		pos = vect ? !in_y[63] : in_z[31];
		xs  = in_x >>> stage;
		ys  = in_y >>> stage;
		at  = apg_pkg::atan_q28(stage);
		if (pos) begin
			nx = in_x + ys;
			ny = in_y - xs;
			nz = in_z + at;
		end else begin
			nx = in_x - ys;
			ny = in_y + xs;
			nz = in_z - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_cry <= in_cry;
			out_x   <= nx;
			out_y   <= ny;
			out_z   <= nz;
		end
	end

endmodule

// File: sv/apg_div_cell.sv
// One quotient bit of a pipelined restoring divider.
module apg_div_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  apg_pkg::sh_t              shift,
	input  logic [31:0]               divisor,
	input  logic                      in_vld,
	input  apg_pkg::carry_t           in_cry,
	input  logic [apg_pkg::REM_W-1:0] in_rem,
	input  logic [31:0]               in_q,
	output logic                      out_vld,
	output apg_pkg::carry_t           out_cry,
	output logic [apg_pkg::REM_W-1:0] out_rem,
	output logic [31:0]               out_q
);

	logic [apg_pkg::REM_W-1:0] dsh;
	logic                      ge;

	always_comb begin
		dsh = apg_pkg::REM_W'(divisor) << shift;
		ge  = in_rem >= dsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_cry <= in_cry;
			out_rem <= ge ? in_rem - dsh : in_rem;
			out_q   <= {in_q[30:0], ge};
		end
	end

endmodule

// File: tb/arc_polyline_point_generator_test.sv
// Testbench for arc_polyline_point_generator: directed and random arcs, predicted vertices.
module arc_polyline_point_generator_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 200;
	localparam longint PI_Q28      = 64'h3243F6A9;
	localparam longint HALF_PI_Q28 = 64'h1921FB54;
	localparam longint TWO_PI_Q28  = 64'h6487ED52;
	localparam longint GAIN        = 64'h26DD3B6A;

	typedef struct {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        r;
		logic signed [31:0] start;
		logic signed [31:0] sweep;
		logic [12:0]        idx;
	} arc_t;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [12:0]        n;
		logic               last;
		logic               beyond;
	} vertex_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               chord_tolerance_we = 1'b0;
	logic [30:0]        chord_tolerance = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] center_x = '0;
	logic signed [31:0] center_y = '0;
	logic [30:0]        arc_radius = '0;
	logic signed [31:0] arc_start = '0;
	logic signed [31:0] sweep_angle = '0;
	logic [12:0]        point_index = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic [12:0]        segment_count;
	logic               last_point;
	logic               index_beyond;

	vertex_t     vertex_q[$];
	logic [30:0] tol_shadow = '0;
	int          errors = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;

	arc_polyline_point_generator u_dut (
		.clk(clk), .arst_n(arst_n),
		.chord_tolerance_we(chord_tolerance_we), .chord_tolerance(chord_tolerance),
		.in_valid(in_valid), .in_stall(in_stall),
		.center_x(center_x), .center_y(center_y), .arc_radius(arc_radius),
		.arc_start(arc_start), .sweep_angle(sweep_angle), .point_index(point_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.point_x(point_x), .point_y(point_y), .segment_count(segment_count),
		.last_point(last_point), .index_beyond(index_beyond)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("arc_polyline_point_generator verification failed");
			$finish;
		end
	end

	function automatic longint atan_step(int i);
		longint unsigned acc, term;
		int e;
		if (i == 0) return 64'h0C90FDAA;
		acc = 0;
		for (int k = 0; ; k++) begin
			e = (2 * k + 1) * i;
			if (e > 62) break;
			term = (64'd1 << (62 - e)) / longint'(2 * k + 1);
			if (k % 2) acc = acc - term;
			else acc = acc + term;
		end
		return longint'((acc + (64'd1 << 33)) >> 34);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint sat_q16(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint segments_for(longint r, longint t, longint sweep);
		longint n, x, y, z, nx, stp, mag;
		n = apg_pkg::FIXED_SEGMENTS;
		if (t > 0 && t < r) begin
			x = (r - t) << 16;
			y = longint'(int_sqrt(t * (2 * r - t))) << 16;
			z = 0;
			for (int i = 0; i < apg_pkg::CORDIC_STAGES; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_step(i);
				end else begin
					nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_step(i);
				end
				x = nx;
			end
			if (z <= 0) begin
				n = apg_pkg::MAX_SEGMENTS;
			end else begin
				stp = 2 * z;
				mag = (sweep < 0) ? -sweep : sweep;
				n = (mag + stp - 1) / stp;
				if (n < apg_pkg::MIN_SEGMENTS) n = apg_pkg::MIN_SEGMENTS;
			end
		end
		if (n > apg_pkg::MAX_SEGMENTS) n = apg_pkg::MAX_SEGMENTS;
		return n;
	endfunction

	function automatic vertex_t predict_vertex(arc_t a, logic [30:0] tol);
		vertex_t v;
		longint n, ang, x, y, z, nx, idx, sweep;
		bit flip;
		idx = longint'(a.idx);
		sweep = longint'(a.sweep);
		n = segments_for(longint'(a.r), longint'(tol), sweep);
		v.px = '0;
		v.py = '0;
		if (idx <= n) begin
			ang = longint'(a.start) + (sweep * idx) / n;
			ang = ang % TWO_PI_Q28;
			if (ang > PI_Q28) ang = ang - TWO_PI_Q28;
			else if (ang < -PI_Q28) ang = ang + TWO_PI_Q28;
			flip = 1'b0;
			if (ang > HALF_PI_Q28) begin
				ang = ang - PI_Q28; flip = 1'b1;
			end else if (ang < -HALF_PI_Q28) begin
				ang = ang + PI_Q28; flip = 1'b1;
			end
			x = longint'(a.r) * GAIN;
			y = 0;
			z = ang;
			for (int i = 0; i < apg_pkg::CORDIC_STAGES; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_step(i);
				end else begin
					nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_step(i);
				end
				x = nx;
			end
			x = (x + (64'sd1 <<< 29)) >>> 30;
			y = (y + (64'sd1 <<< 29)) >>> 30;
			if (flip) begin
				x = -x; y = -y;
			end
			v.px = 32'(sat_q16(longint'(a.cx) + x));
			v.py = 32'(sat_q16(longint'(a.cy) + y));
		end
		v.n = 13'(n);
		v.last = (idx == n);
		v.beyond = (idx > n);
		return v;
	endfunction

	function automatic int gap_len();
		int p;
		if (quiet) return 0;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_arc(arc_t a);
		int gap;
		gap = gap_len();
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		center_x <= a.cx;
		center_y <= a.cy;
		arc_radius <= a.r;
		arc_start <= a.start;
		sweep_angle <= a.sweep;
		point_index <= a.idx;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		vertex_q.insert(vertex_q.size(), predict_vertex(a, tol_shadow));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (vertex_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_tolerance(logic [30:0] t);
		drain();
		repeat (4) @(posedge clk);
		chord_tolerance <= t;
		chord_tolerance_we <= 1'b1;
		@(posedge clk);
		chord_tolerance_we <= 1'b0;
		tol_shadow = t;
	endtask

	task automatic send_one(logic signed [31:0] cx, logic signed [31:0] cy, logic [30:0] r,
			logic signed [31:0] st, logic signed [31:0] sw, logic [12:0] idx);
		arc_t a;
		a.cx = cx; a.cy = cy; a.r = r; a.start = st; a.sweep = sw; a.idx = idx;
		send_arc(a);
	endtask

	task automatic random_arc(output arc_t a);
		int sel;
		logic [31:0] w;
		a.cx = $urandom;
		a.cy = $urandom;
		if ($urandom_range(0, 1)) begin
			a.cx = a.cx >>> 8; a.cy = a.cy >>> 8;
		end
		sel = $urandom_range(0, 4);
		case (sel)
			0: a.r = 31'($urandom_range(0, 65535));
			1: a.r = 31'($urandom);
			2: a.r = 31'($urandom_range(0, 1 << 22));
			default: begin
				w = 32'(tol_shadow) + $urandom_range(1, 1 << 24);
				a.r = w[31] ? 31'h7FFFFFFF : w[30:0];
			end
		endcase
		a.start = $urandom;
		if ($urandom_range(0, 2) == 0) begin
			a.sweep = $urandom;
		end else begin
			a.sweep = $urandom_range(0, 32'h6487ED52);
			if ($urandom_range(0, 1)) a.sweep = -a.sweep;
		end
		a.idx = 0;
	endtask

	task automatic walk_arc();
		arc_t a;
		int n, top;
		random_arc(a);
		quiet = ($urandom_range(0, 7) == 0);
		n = int'(segments_for(longint'(a.r), longint'(tol_shadow), longint'(a.sweep)));
		if (n <= 12) begin
			top = n + $urandom_range(0, 1);
			for (int i = 0; i <= top; i++) begin
				a.idx = 13'(i); send_arc(a);
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				a.idx = 13'(i); send_arc(a);
			end
			a.idx = 13'($urandom_range(0, n)); send_arc(a);
			a.idx = 13'(n - 1); send_arc(a);
			a.idx = 13'(n); send_arc(a);
			a.idx = 13'(n + 1); send_arc(a);
		end
	endtask

	task automatic random_phase(logic [30:0] t, int items);
		arc_t a;
		int sent;
		set_tolerance(t);
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 4) == 0) begin
				random_arc(a);
				a.idx = 13'($urandom);
				quiet = 1'b0;
				send_arc(a);
				sent++;
			end else begin
				walk_arc();
				sent += 8;
			end
		end
	endtask

	task automatic test_fixed_segments();
		send_one(0, 0, 31'h10000, 0, 32'h1921FB54, 0);
		send_one(0, 0, 31'h10000, 0, 32'h1921FB54, 4);
		send_one(0, 0, 31'h10000, 0, 32'h1921FB54, 8);
		send_one(0, 0, 31'h10000, 0, 32'h1921FB54, 9);
		send_one(0, 0, 31'h10000, 0, 32'h1921FB54, 13'h1FFF);
		send_one(32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 0, 0, 0);
		send_one(32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 5);
		send_one(32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 3);
		send_one(100, -100, 0, 32'sh3243F6A9, 32'sh80000000, 8);
		send_one(0, 0, 31'h40000, -32'sh3243F6A9, 32'sh6487ED52, 2);
	endtask

	task automatic test_tolerance_limits();
		set_tolerance(31'h1000);
		send_one(0, 0, 31'h1000, 0, 32'h1921FB54, 1);
		send_one(0, 0, 31'h0800, 0, 32'h1921FB54, 1);
		send_one(0, 0, 31'h10000, 0, 0, 2);
		send_one(0, 0, 31'h10000, 0, 32'h6487ED52, 0);
		send_one(0, 0, 31'h10000, 0, -32'sh6487ED52, 3);
		set_tolerance(31'h1);
		send_one(0, 0, 31'h7FFFFFFF, 0, 32'sh7FFFFFFF, 4096);
		send_one(0, 0, 31'h7FFFFFFF, 0, 32'sh80000000, 4097);
		send_one(0, 0, 31'h2, 0, 32'sh7FFFFFFF, 1);
		set_tolerance(31'h7FFFFFFF);
		send_one(5, 5, 31'h7FFFFFFF, 0, 32'h1921FB54, 8);
		send_one(5, 5, 31'h10000, 0, 32'h1921FB54, 8);
	endtask

	task automatic test_random_arcs();
		random_phase(31'h0, 80);
		random_phase(31'h1, 80);
		random_phase(31'h10000, 80);
		random_phase(31'($urandom_range(16, 1 << 20)), 80);
		random_phase(31'h7FFFFFFF, 60);
		random_phase(31'($urandom), 80);
	endtask

	initial begin
		int mode, len;
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 9);
			len = $urandom_range(5, 80);
			repeat (len) begin
				if (mode < 3) out_stall <= 1'b0;
				else if (mode == 9) out_stall <= ($urandom_range(0, 3) != 0);
				else out_stall <= ($urandom_range(0, 4) == 0);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (vertex_q.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h n=%0d", $time, point_x, point_y,
					segment_count);
				errors++;
			end else begin
				e = vertex_q.pop_front();
				if (point_x !== e.px) begin
					$display("%0t: point_x exp %h act %h", $time, e.px, point_x); errors++;
				end
				if (point_y !== e.py) begin
					$display("%0t: point_y exp %h act %h", $time, e.py, point_y); errors++;
				end
				if (segment_count !== e.n) begin
					$display("%0t: segment_count exp %0d act %0d", $time, e.n, segment_count);
					errors++;
				end
				if (last_point !== e.last) begin
					$display("%0t: last_point exp %b act %b", $time, e.last, last_point);
					errors++;
				end
				if (index_beyond !== e.beyond) begin
					$display("%0t: index_beyond exp %b act %b", $time, e.beyond, index_beyond);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fixed_segments();
		test_tolerance_limits();
		test_random_arcs();
		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("arc_polyline_point_generator verification clean");
		end else begin
			$display("arc_polyline_point_generator verification failed");
		end
		$finish;
	end

endmodule
